// ===== rtl/core/fractional_delay_line_linear_interp_core_defines.svh =====
// Assertion helpers for the fractional delay line core.
`ifndef FRACTIONAL_DELAY_LINE_LINEAR_INTERP_CORE_DEFINES_SVH
`define FRACTIONAL_DELAY_LINE_LINEAR_INTERP_CORE_DEFINES_SVH

// prop must hold in the same cycle as cond
`define FDLLI_ASSERT_NOW(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// prop must hold in the cycle after cond
`define FDLLI_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/core/fdlli_pkg.sv =====
package fdlli_pkg;

  localparam int unsigned MAX_LEN_DEF = 4096;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DELAY_W  = 28;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DINT_W   = DELAY_W - FRAC_W;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 28'd134217728;

  // APB side
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PADDR_W = 3;

  // register index (paddr[2])
  localparam logic REG_DELAY = 1'b0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // per-item read control, address unit -> mixer
  typedef struct packed {
    logic              fwd0;    // tap 0 hits the entry written this beat
    logic              fwd1;
    logic              wr0;     // tap 0 entry has been written since reset
    logic              wr1;
    logic [FRAC_W-1:0] weight;  // weight of tap 1
  } mix_ctl_t;

endpackage

// ===== rtl/core/fdlli_ram.sv =====
module fdlli_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/core/fdlli_addr.sv =====
module fdlli_addr #(
  parameter int unsigned MAX_LEN = fdlli_pkg::MAX_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fdlli_pkg::DELAY_W-1:0] delay,
  input  logic                        adv,
  output logic [$clog2(MAX_LEN)-1:0]  wr_addr,
  output logic [$clog2(MAX_LEN)-1:0]  rd_addr0,
  output logic [$clog2(MAX_LEN)-1:0]  rd_addr1,
  output fdlli_pkg::mix_ctl_t         ctl
);

  import fdlli_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_LEN);
  localparam logic [AW:0] LEN   = (AW+1)'(MAX_LEN);
  localparam logic [AW:0] HALF  = (AW+1)'(MAX_LEN >> 1);
  localparam logic [AW:0] OFS   = LEN - HALF;
  localparam logic [23:0] RECIP = 24'((64'd1 << 24) / MAX_LEN);

  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW:0]   fill_r, fill_nxt;
  logic [DINT_W-1:0] q_r;
  logic [AW-1:0]     red_r;

  // delay integer part modulo MAX_LEN: reciprocal estimate, then one correction
  logic [DINT_W-1:0] dint;
  logic [35:0]       qprod;
  logic [28:0]       qlen;
  logic [DINT_W-1:0] rem, red_w;

  assign dint  = delay[DELAY_W-1:FRAC_W];
  assign qprod = {24'd0, dint} * {12'd0, RECIP};
  assign qlen  = 29'(q_r) * 29'(MAX_LEN);
  assign rem   = dint - qlen[DINT_W-1:0];

  always_comb begin
    if ({6'd0, rem} >= 18'(MAX_LEN)) begin
      red_w = rem - DINT_W'(MAX_LEN);
    end else begin
      red_w = rem;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= qprod[35:24];
    red_r <= AW'(red_w);
  end

  // read position = write position - delay, modulo the store
  logic [FRAC_W-1:0] frac;
  logic              borrow;
  logic [AW:0]       t;
  logic [AW-1:0]     i0, i1;
  logic [AW:0]       n_inc;

  assign frac   = delay[FRAC_W-1:0];
  assign borrow = |frac;
  assign t      = {1'b0, wp_r} + LEN - {1'b0, red_r} - (AW+1)'(borrow);

  always_comb begin
    if (t >= LEN) begin
      i0 = AW'(t - LEN);
    end else begin
      i0 = AW'(t);
    end
    if ({1'b0, i0} == LEN - 1'b1) begin
      i1 = '0;
    end else begin
      i1 = i0 + 1'b1;
    end
  end

  assign n_inc = (fill_r == LEN) ? LEN : fill_r + 1'b1;

  // writes run in order from HALF, so an entry was written iff its
  // distance from HALF is below the write count
  function automatic logic written(input logic [AW-1:0] idx, input logic [AW:0] cnt);
    logic [AW:0] u;
    logic [AW:0] off;
    u   = {1'b0, idx} + OFS;
    off = (u >= LEN) ? u - LEN : u;
    return off < cnt;
  endfunction

  always_comb begin
    ctl.fwd0   = (i0 == wp_r);
    ctl.fwd1   = (i1 == wp_r);
    ctl.wr0    = written(i0, n_inc);
    ctl.wr1    = written(i1, n_inc);
    ctl.weight = FRAC_W'(0) - frac;
  end

  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (adv) begin
      fill_nxt = n_inc;
      if ({1'b0, wp_r} == LEN - 1'b1) begin
        wp_nxt = '0;
      end else begin
        wp_nxt = wp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= AW'(HALF);
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign wr_addr  = wp_r;
  assign rd_addr0 = i0;
  assign rd_addr1 = i1;

endmodule

// ===== rtl/core/fdlli_mix.sv =====
module fdlli_mix (
  input  logic                clk,
  input  logic                load,
  input  fdlli_pkg::sample_t  rdata0,
  input  fdlli_pkg::sample_t  rdata1,
  input  fdlli_pkg::mix_ctl_t ctl,
  input  fdlli_pkg::sample_t  smp,
  output fdlli_pkg::sample_t  result
);

  import fdlli_pkg::*;

  sample_t s0, s1;
  logic signed [SAMPLE_W:0]     diff;
  logic signed [FRAC_W:0]       wgt;
  logic signed [33:0]           prod_w;

  // the sample written this beat wins over the old RAM word
  always_comb begin
    if (ctl.fwd0) begin
      s0 = smp;
    end else if (ctl.wr0) begin
      s0 = rdata0;
    end else begin
      s0 = '0;
    end
    if (ctl.fwd1) begin
      s1 = smp;
    end else if (ctl.wr1) begin
      s1 = rdata1;
    end else begin
      s1 = '0;
    end
  end

  // s0*(1-a) + s1*a == s0 + (s1-s0)*a
  assign diff   = (SAMPLE_W+1)'(s1) - (SAMPLE_W+1)'(s0);
  assign wgt    = $signed({1'b0, ctl.weight});
  assign prod_w = 34'(diff) * 34'(wgt);

  sample_t            s0_r;
  logic signed [33:0] prod_r;

  always_ff @(posedge clk) begin
    if (load) begin
      s0_r   <= s0;
      prod_r <= prod_w;
    end
  end

  logic signed [33:0] acc, biased;
  logic signed [17:0] rnd;

  assign acc    = $signed({{2{s0_r[SAMPLE_W-1]}}, s0_r, 16'd0}) + prod_r;
  assign biased = acc + 34'sd32768;
  assign rnd    = biased[33:16];

  always_comb begin
    if (rnd > 18'sd32767) begin
      result = 16'sh7fff;
    end else if (rnd < -18'sd32768) begin
      result = 16'sh8000;
    end else begin
      result = SAMPLE_W'(rnd);
    end
  end

endmodule

// ===== rtl/core/fractional_delay_line_linear_interp_core.sv =====
// Channel  Handshake                 Payload
// in       in_valid / in_ready       in_sample_in   (Q1.15)
// out      out_valid / out_ready     out_sample_out (Q1.15)
// cfg      APB, pready tied high     delay_amount at byte address 0
//
// One beat per cycle sustained unless out_ready or a delay settle stalls it;
// out_valid follows RAM read, multiply, round/saturate into the output register.
// Two RAM reads and one write per beat go to a single 1W2R store.
// Reset is synchronous; in_ready stays low after reset and after each delay
// write while the delay is reduced modulo the store length.
// Up to three beats are buffered while out_ready is low; then in_ready drops.
`include "fractional_delay_line_linear_interp_core_defines.svh"

module fractional_delay_line_linear_interp_core #(
  parameter int unsigned MAX_LEN = fdlli_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [fdlli_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [fdlli_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdlli_pkg::PADDR_W-1:0] paddr,
  input  logic [fdlli_pkg::PDATA_W-1:0] pwdata,
  output logic [fdlli_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  import fdlli_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_LEN);
  localparam logic [AW:0] LEN     = (AW+1)'(MAX_LEN);
  localparam logic [1:0]  SETTLE  = 2'd2;

  // config
  logic               cfg_we;
  logic [DELAY_W-1:0] delay_r;
  logic [1:0]         settle_r;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_DELAY);
  assign prdata = (paddr[2] == REG_DELAY) ? PDATA_W'(delay_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= DELAY_RESET;
      settle_r <= SETTLE;
    end else begin
      if (cfg_we) begin
        delay_r  <= pwdata[DELAY_W-1:0];
        settle_r <= SETTLE;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // pipeline control
  logic     acc;
  logic     s1_v_r, s2_v_r, out_v_r;
  logic     s1_en, s2_en, out_en;
  mix_ctl_t ctl_w, s1_ctl_r;
  sample_t  s1_smp_r, out_smp_r, mix_res;

  assign out_en   = !out_v_r || out_ready;
  assign s2_en    = !s2_v_r || out_en;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_ready = s1_en && (settle_r == 2'd0);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= acc;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
      if (out_en) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctl_r <= ctl_w;
      s1_smp_r <= in_sample_in;
    end
    if (out_en && s2_v_r) begin
      out_smp_r <= mix_res;
    end
  end

  // store
  logic [AW-1:0] wr_addr, rd_addr0, rd_addr1;
  logic [SAMPLE_W-1:0] rdata0, rdata1;

  fdlli_addr #(
    .MAX_LEN(MAX_LEN)
  ) u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .delay   (delay_r),
    .adv     (acc),
    .wr_addr (wr_addr),
    .rd_addr0(rd_addr0),
    .rd_addr1(rd_addr1),
    .ctl     (ctl_w)
  );

  fdlli_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_LEN)
  ) u_ram (
    .clk    (clk),
    .we     (acc),
    .waddr  (wr_addr),
    .wdata  (in_sample_in),
    .re     (acc),
    .raddr_a(rd_addr0),
    .raddr_b(rd_addr1),
    .rdata_a(rdata0),
    .rdata_b(rdata1)
  );

  fdlli_mix u_mix (
    .clk   (clk),
    .load  (s2_en && s1_v_r),
    .rdata0($signed(rdata0)),
    .rdata1($signed(rdata1)),
    .ctl   (s1_ctl_r),
    .smp   (s1_smp_r),
    .result(mix_res)
  );

  assign out_valid      = out_v_r;
  assign out_sample_out = out_smp_r;

  logic rd_in_range;
  logic s1_stall;

  assign rd_in_range = ({1'b0, rd_addr0} < LEN) && ({1'b0, rd_addr1} < LEN);
  assign s1_stall    = s1_v_r && !s2_en;

  `FDLLI_ASSERT_NEXT(a_acc_to_s1, clk, rst_n, acc, s1_v_r, "accepted beat not in stage 1")
  `FDLLI_ASSERT_NOW(a_rd_range, clk, rst_n, acc, rd_in_range, "read address beyond store")
  `FDLLI_ASSERT_NEXT(a_cfg_settle, clk, rst_n, cfg_we, !in_ready, "beat during delay settle")
  `FDLLI_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_stall, s1_v_r && $stable(s1_smp_r), "stage 1 lost")

endmodule
